// ===== hw/rtl/msb_first_bit_packer_core_assert.svh =====
// Assertion macros shared by the bit packer checker.
// Depends on nothing; callers supply clk and rst_n in scope.
`ifndef MSB_FIRST_BIT_PACKER_CORE_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define MBP_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MBP_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mbp_pkg.sv =====
// Shared types and constants for the MSB-first bit packer.
// Used by the interfaces, the front and back parts and the top level.
`timescale 1ns / 1ps

package mbp_pkg;

    localparam int VALUE_W   = 32;
    localparam int WIDTH_W   = 6;
    localparam int CAP_W     = 13;
    localparam int POS_W     = 13;
    localparam int OUT_POS_W = 12;
    localparam int BYTE_W    = 8;
    localparam int BITPOS_W  = 3;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CAP_W-1:0]   CAP_RESET = 13'd4096;
    localparam logic [WIDTH_W-1:0] MAX_FIELD = 6'd32;

    typedef struct packed {
        logic [VALUE_W-1:0] aligned;   // field bits pushed up to bit 31
        logic [WIDTH_W-1:0] width;
        logic               bad;       // width of 0 or above 32
    } queue_entry_t;

    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_head_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } back_state_t;

endpackage

// ===== hw/rtl/mbp_stream_if.sv =====
// Stream channels of the bit packer: field requests in, byte results out.
// Depends on mbp_pkg for field widths.
`timescale 1ns / 1ps

interface mbp_field_if
    import mbp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] field_value;
    logic [WIDTH_W-1:0] field_width;

    modport source (output valid, output field_value, output field_width, input ready);
    modport sink   (input valid, input field_value, input field_width, output ready);
endinterface

interface mbp_byte_if
    import mbp_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [OUT_POS_W-1:0] byte_position;
    logic [BYTE_W-1:0]    byte_contents;
    logic                 byte_touched;
    logic                 accepted;
    logic                 last_of_item;

    modport source (output valid, output byte_position, output byte_contents,
                    output byte_touched, output accepted, output last_of_item,
                    input ready);
    modport sink   (input valid, input byte_position, input byte_contents,
                    input byte_touched, input accepted, input last_of_item,
                    output ready);
endinterface

// ===== hw/rtl/mbp_front.sv =====
// Front part: accepts field requests, checks the width, left-aligns the bits
// and holds them in a short queue for the back part. Depends on mbp_pkg.
`timescale 1ns / 1ps

module mbp_front
    import mbp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    mbp_field_if.sink          field_in,
    input  logic               pop,
    output queue_head_t        head
);

    queue_entry_t           q_reg [QDEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]      count_reg, count_next;
    logic                   push;
    logic                   do_pop;
    logic [WIDTH_W-1:0]     shift_amt;
    queue_entry_t           new_entry;

    assign field_in.ready = (count_reg != QCNT_W'(QDEPTH));
    assign push   = field_in.valid && field_in.ready;
    assign do_pop = pop && (count_reg != '0);

    // Shifting left by 32 - width drops the bits above the width.
    always_comb
    begin
        shift_amt         = MAX_FIELD - field_in.field_width;
        new_entry.width   = field_in.field_width;
        new_entry.bad     = (field_in.field_width == '0) || (field_in.field_width > MAX_FIELD);
        new_entry.aligned = field_in.field_value << shift_amt[4:0];
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_entry;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = q_reg[rd_ptr_reg];

endmodule

// ===== hw/rtl/mbp_back.sv =====
// Back part: keeps the partial byte, bit and byte positions and emits one
// byte result per cycle into an output register unless the output stalls. Depends on mbp_pkg.
`timescale 1ns / 1ps

module mbp_back
    import mbp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CAP_W-1:0]   cap,
    input  queue_head_t        head,
    output logic               pop,
    mbp_byte_if.source         byte_out
);

    back_state_t          state_reg, state_next;
    logic [BYTE_W-1:0]    partial_reg, partial_next;
    logic [BITPOS_W-1:0]  bitpos_reg, bitpos_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [VALUE_W-1:0]   aligned_reg, aligned_next;
    logic [WIDTH_W-1:0]   rem_reg, rem_next;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_POS_W-1:0] out_pos_reg, out_pos_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                 out_touched_reg, out_touched_next;
    logic                 out_ok_reg, out_ok_next;
    logic                 out_last_reg, out_last_next;

    logic                 out_free;
    logic [VALUE_W-1:0]   src_aligned;
    logic [WIDTH_W-1:0]   src_rem;
    logic [3:0]           room;
    logic [3:0]           new_bitpos;
    logic [BYTE_W-1:0]    contents;
    logic [POS_W:0]       pos_inc;
    logic                 at_end;
    logic                 full;
    logic                 do_step;

    assign out_free = !out_valid_reg || byte_out.ready;

    always_comb
    begin
        src_aligned = (state_reg == ST_RUN) ? aligned_reg : head.entry.aligned;
        src_rem     = (state_reg == ST_RUN) ? rem_reg : head.entry.width;
        room        = 4'd8 - {1'b0, bitpos_reg};
        contents    = partial_reg | (src_aligned[VALUE_W-1 -: BYTE_W] >> bitpos_reg);
        pos_inc     = {1'b0, pos_reg} + 1'b1;
        at_end      = pos_inc >= {1'b0, cap};
        full        = pos_reg >= cap;
        new_bitpos  = {1'b0, bitpos_reg} + src_rem[3:0];
    end

    always_comb
    begin
        state_next       = state_reg;
        partial_next     = partial_reg;
        bitpos_next      = bitpos_reg;
        pos_next         = pos_reg;
        aligned_next     = aligned_reg;
        rem_next         = rem_reg;
        out_valid_next   = out_valid_reg && !byte_out.ready;
        out_pos_next     = out_pos_reg;
        out_byte_next    = out_byte_reg;
        out_touched_next = out_touched_reg;
        out_ok_next      = out_ok_reg;
        out_last_next    = out_last_reg;
        pop              = 1'b0;
        do_step          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    pop = 1'b1;
                    if (head.entry.bad || full)
                    begin
                        // Refused: one status result, state untouched.
                        out_valid_next   = 1'b1;
                        out_pos_next     = pos_reg[OUT_POS_W-1:0];
                        out_byte_next    = '0;
                        out_touched_next = 1'b0;
                        out_ok_next      = 1'b0;
                        out_last_next    = 1'b1;
                    end
                    else
                    begin
                        do_step = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                do_step = out_free;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_step)
        begin
            out_valid_next   = 1'b1;
            out_pos_next     = pos_reg[OUT_POS_W-1:0];
            out_byte_next    = contents;
            out_touched_next = 1'b1;
            if (src_rem > {2'b00, room})
            begin
                // Byte completes with bits left over.
                pos_next     = pos_inc[POS_W-1:0];
                partial_next = '0;
                bitpos_next  = '0;
                if (at_end)
                begin
                    // Stream full: drop the rest of the field.
                    out_ok_next   = 1'b0;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    out_ok_next   = 1'b1;
                    out_last_next = 1'b0;
                    aligned_next  = src_aligned << room;
                    rem_next      = src_rem - {2'b00, room};
                    state_next    = ST_RUN;
                end
            end
            else
            begin
                out_ok_next   = 1'b1;
                out_last_next = 1'b1;
                state_next    = ST_IDLE;
                if (new_bitpos[3])
                begin
                    pos_next     = pos_inc[POS_W-1:0];
                    partial_next = '0;
                    bitpos_next  = '0;
                end
                else
                begin
                    partial_next = contents;
                    bitpos_next  = new_bitpos[BITPOS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            partial_reg   <= '0;
            bitpos_reg    <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            partial_reg   <= partial_next;
            bitpos_reg    <= bitpos_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        aligned_reg     <= aligned_next;
        rem_reg         <= rem_next;
        out_pos_reg     <= out_pos_next;
        out_byte_reg    <= out_byte_next;
        out_touched_reg <= out_touched_next;
        out_ok_reg      <= out_ok_next;
        out_last_reg    <= out_last_next;
    end

    assign byte_out.valid         = out_valid_reg;
    assign byte_out.byte_position = out_pos_reg;
    assign byte_out.byte_contents = out_byte_reg;
    assign byte_out.byte_touched  = out_touched_reg;
    assign byte_out.accepted      = out_ok_reg;
    assign byte_out.last_of_item  = out_last_reg;

endmodule

// ===== hw/rtl/msb_first_bit_packer_core.sv =====
// MSB-first bit packer. Each accepted request appends 1 to 32 bits to a byte
// stream and yields one result per byte it touches; a refused request (width 0
// or above 32, or stream full) yields a single status result. A valid field
// touches 1 to 5 bytes. The back sequencer emits one byte per cycle into its
// output register while the output is not stalled. A two-entry queue sits
// between the request side and the sequencer, so requests are taken while
// results wait. The effective capacity is the smaller of the capacity
// register and MAX_BYTES; write the register only while the block is idle.
`timescale 1ns / 1ps

module msb_first_bit_packer_core
    import mbp_pkg::*;
#(
    parameter int MAX_BYTES = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CAP_W-1:0]   cfg_wdata,
    mbp_field_if.sink          field_in,
    mbp_byte_if.source         byte_out
);

    localparam int            LIM_W = 17;
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_BYTES);

    logic [CAP_W-1:0] cap_reg;
    logic [LIM_W-1:0] cap_wide;
    logic [CAP_W-1:0] cap_eff;
    queue_head_t      head;
    logic             pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // Clamp to MAX_BYTES; the result never exceeds the register value.
    always_comb
    begin
        cap_wide = (MAX_LIM < LIM_W'(cap_reg)) ? MAX_LIM : LIM_W'(cap_reg);
        cap_eff  = cap_wide[CAP_W-1:0];
    end

    mbp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .field_in (field_in),
        .pop      (pop),
        .head     (head)
    );

    mbp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cap      (cap_eff),
        .head     (head),
        .pop      (pop),
        .byte_out (byte_out)
    );

endmodule

// ===== hw/rtl/mbp_checker.sv =====
// Port-level checks on the bit packer, bound to the top level.
// Depends on mbp_pkg and msb_first_bit_packer_core_assert.svh.
`timescale 1ns / 1ps
`include "msb_first_bit_packer_core_assert.svh"

module mbp_checker
    import mbp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [OUT_POS_W-1:0] out_pos,
    input logic [BYTE_W-1:0]    out_byte,
    input logic                 out_touched,
    input logic                 out_ok,
    input logic                 out_last
);

    logic                 in_hs;
    logic                 out_hs;
    logic [2:0]           pending_reg;
    logic                 prev_open_reg;
    logic [OUT_POS_W-1:0] prev_pos_reg;

    assign in_hs  = in_valid && in_ready;
    assign out_hs = out_valid && out_ready;

    // Track requests whose final result has not been taken yet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            prev_open_reg <= 1'b0;
            prev_pos_reg  <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {2'b00, in_hs} - {2'b00, out_hs && out_last};
            if (out_hs)
            begin
                prev_open_reg <= !out_last;
                prev_pos_reg  <= out_pos;
            end
        end
    end

    `MBP_CHECK_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_pos) && $stable(out_byte) && $stable(out_ok) &&
        $stable(out_touched) && $stable(out_last), "stalled result changed")
    `MBP_CHECK(a_last_has_request, out_hs && out_last, pending_reg != 3'd0,
        "final result without an open request")
    `MBP_CHECK(a_pending_bound, 1'b1, pending_reg <= 3'd3,
        "too many open requests")
    `MBP_CHECK(a_next_byte, out_hs && prev_open_reg,
        out_touched && (out_pos == OUT_POS_W'(prev_pos_reg + 1'b1)),
        "continuation result not at the next byte")

endmodule

bind msb_first_bit_packer_core mbp_checker u_mbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (field_in.valid),
    .in_ready    (field_in.ready),
    .out_valid   (byte_out.valid),
    .out_ready   (byte_out.ready),
    .out_pos     (byte_out.byte_position),
    .out_byte    (byte_out.byte_contents),
    .out_touched (byte_out.byte_touched),
    .out_ok      (byte_out.accepted),
    .out_last    (byte_out.last_of_item)
);
